FILE: design/toroidal_window_dirty_slabs_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dirty-slab sequencer
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_WINDOW_DIRTY_SLABS_TOP_MACROS_SVH
`define TOROIDAL_WINDOW_DIRTY_SLABS_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define TWDS_CHECK_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define TWDS_CHECK_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/twds_pkg.sv
// ----------------------------------------------------------------------------
// twds_pkg
// Shared types and constants of the toroidal window dirty-slab sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package twds_pkg;

  // Divider operand widths
  localparam int DIVD_W = 32;
  localparam int DIVS_W = 24;

  // Configuration register widths and reset values
  localparam int GRID_RES_W = 9;
  localparam int SPACING_W  = 24;
  localparam logic [GRID_RES_W-1:0] GRID_RES_RST = 9'd64;
  localparam logic [SPACING_W-1:0]  SPACING_RST  = 24'd256;

  // Register indexes (paddr[2])
  localparam logic REG_GRID_RES = 1'b0;
  localparam logic REG_SPACING  = 1'b1;

  // Axis indexes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Piece counts per axis
  localparam logic [1:0] PN_NONE = 2'd0;
  localparam logic [1:0] PN_ONE  = 2'd1;
  localparam logic [1:0] PN_TWO  = 2'd2;

  // Output field widths
  localparam int TEXEL_W = 8;
  localparam int COUNT_W = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SNAP_GO,
    ST_SNAP_WAIT,
    ST_PLAN,
    ST_SLAB,
    ST_AXIS,
    ST_MOD0_WAIT,
    ST_PIECE0,
    ST_MOD1_WAIT,
    ST_PIECE1,
    ST_EMIT,
    ST_FINISH
  } twds_state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } twds_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [DIVS_W-1:0] rem;
  } twds_div_resp_t;

endpackage

`default_nettype wire

FILE: design/toroidal_window_dirty_slabs_top.sv
// ----------------------------------------------------------------------------
// toroidal_window_dirty_slabs_top
// Snaps a camera position to a probe center and emits the wrap-resolved
// dirty pieces of a toroidal probe window, one piece per result beat.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake           | beat
//   in_      | input     | in_valid / in_stall | one camera position
//   out_     | output    | out_valid/out_stall | one dirty piece
//   APB      | input     | psel/penable/pready | one register write or read
//
// Sequence: snapping divides each axis in turn in the shared divider;
//   each slab then divides once per non-empty axis for its texel wrap, once
//   more on an axis whose range wraps past 2^31, and then emits its pieces.
// Reset: rst_n is synchronous; it loads the register defaults and clears
//   the window. The block takes no item while a camera beat is in work.
// Stalls: out_stall holds the piece register; the sequencer waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "toroidal_window_dirty_slabs_top_macros.svh"

module toroidal_window_dirty_slabs_top #(
  parameter int MAX_GRID_RESOLUTION = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // camera channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_camera_x,
  input  logic signed [31:0] in_camera_y,
  input  logic signed [31:0] in_camera_z,
  // piece channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_world_start_x,
  output logic signed [31:0] out_world_start_y,
  output logic signed [31:0] out_world_start_z,
  output logic [7:0]         out_texel_start_x,
  output logic [7:0]         out_texel_start_y,
  output logic [7:0]         out_texel_start_z,
  output logic [8:0]         out_count_x,
  output logic [8:0]         out_count_y,
  output logic [8:0]         out_count_z,
  output logic               out_last_piece,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int RW = $clog2(MAX_GRID_RESOLUTION + 1);
  localparam int EW = (RW > twds_pkg::COUNT_W) ? RW : twds_pkg::COUNT_W;

  twds_pkg::twds_state_t state_r, state_nxt;

  // configuration
  logic [twds_pkg::GRID_RES_W-1:0] grid_res_r;
  logic [twds_pkg::SPACING_W-1:0]  spacing_r;

  // window state
  logic [31:0] wc_r [3];
  logic        valid_r;

  // item work registers
  logic [31:0]   cam_r [3];
  logic [31:0]   nc_r [3];
  logic [1:0]    ax_r;
  logic [1:0]    slab_ax_r;
  logic [2:0]    mask_r;
  logic [2:0]    band_ok_r;
  logic [2:0]    pos_r;
  logic          init_pend_r;
  logic          band_en_r;
  logic          last_slab_r;
  logic [31:0]   cur_r;
  logic [31:0]   remain_r;

  // per-axis pieces of the current slab
  logic [31:0]   pw0_r [3];
  logic [31:0]   pw1_r [3];
  logic [RW-1:0] pt0_r [3];
  logic [RW-1:0] pt1_r [3];
  logic [RW-1:0] pc0_r [3];
  logic [RW-1:0] pc1_r [3];
  logic [1:0]    pn_r [3];
  logic          i_r, j_r, k_r;

  // piece output register
  logic          out_valid_r;
  logic [31:0]   o_world_r [3];
  logic [RW-1:0] o_texel_r [3];
  logic [RW-1:0] o_count_r [3];
  logic          o_last_r;

  twds_pkg::twds_div_req_t  div_req;
  twds_pkg::twds_div_resp_t div_resp;

  twds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .resp  (div_resp)
  );

  // --------------------------------------------------------------------------
  // Effective resolution and half window
  // --------------------------------------------------------------------------
  logic [31:0]   gr32;
  logic [31:0]   res32;
  logic [RW-1:0] res_w;
  logic [31:0]   half32;

  always_comb begin
    gr32   = 32'(grid_res_r);
    res32  = (gr32 < 32'd2) ? 32'd2 :
             (gr32 > 32'(MAX_GRID_RESOLUTION)) ? 32'(MAX_GRID_RESOLUTION) : gr32;
    res_w  = res32[RW-1:0];
    half32 = res32 >> 1;
  end

  // --------------------------------------------------------------------------
  // Snap: floor of camera / spacing from the unsigned quotient
  // --------------------------------------------------------------------------
  logic [31:0] cam_cur;
  logic [31:0] cam_abs;
  logic [23:0] spacing_eff;
  logic [31:0] snap_val;

  always_comb begin
    cam_cur     = cam_r[ax_r];
    cam_abs     = cam_cur[31] ? (32'd0 - cam_cur) : cam_cur;
    spacing_eff = (spacing_r == '0) ? 24'd1 : spacing_r;
    if (!cam_cur[31]) begin
      snap_val = div_resp.quot;
    end else if (div_resp.rem != '0) begin
      snap_val = ~div_resp.quot;
    end else begin
      snap_val = 32'd0 - div_resp.quot;
    end
  end

  // --------------------------------------------------------------------------
  // Motion per axis against the stored center
  // --------------------------------------------------------------------------
  logic [31:0] delta [3];
  logic [2:0]  moved;
  logic [2:0]  near;
  logic [2:0]  fwd;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      delta[a] = nc_r[a] - wc_r[a];
      moved[a] = (delta[a] != 32'd0);
      near[a]  = ($signed(delta[a]) < $signed(res32)) &&
                 ($signed(delta[a]) > -$signed(res32));
      fwd[a]   = !delta[a][31];
    end
  end

  // --------------------------------------------------------------------------
  // Range of the current axis within the current slab
  // --------------------------------------------------------------------------
  logic [31:0] nc_cur, wc_cur;
  logic        use_band;
  logic [31:0] ax_lo, ax_hi, ax_len;
  logic        ax_has;
  logic [31:0] lo_abs;

  always_comb begin
    nc_cur   = nc_r[ax_r];
    wc_cur   = wc_r[ax_r];
    use_band = band_en_r && (ax_r == slab_ax_r) && band_ok_r[ax_r];
    ax_lo    = nc_cur - half32;
    ax_hi    = nc_cur + half32;
    if (use_band) begin
      if (pos_r[ax_r]) begin
        ax_lo = wc_cur + half32;
      end else begin
        ax_hi = wc_cur - half32;
      end
    end
    ax_len = ax_hi - ax_lo;
    ax_has = !ax_len[31] && (ax_len != 32'd0);
    lo_abs = ax_lo[31] ? (32'd0 - ax_lo) : ax_lo;
  end

  // --------------------------------------------------------------------------
  // Piece from the wrap remainder of cur_r
  // --------------------------------------------------------------------------
  logic [RW-1:0] rm;
  logic [RW-1:0] wrap_w;
  logic [RW-1:0] space_w;
  logic [RW-1:0] len_w;
  logic [31:0]   rem_after;
  logic          more;
  logic [31:0]   cur_next;
  logic          ovf;
  logic [RW-1:0] len1_w;
  logic [31:0]   next_abs;

  always_comb begin
    rm        = div_resp.rem[RW-1:0];
    wrap_w    = (cur_r[31] && (rm != '0)) ? (res_w - rm) : rm;
    space_w   = res_w - wrap_w;
    len_w     = (remain_r < 32'(space_w)) ? remain_r[RW-1:0] : space_w;
    rem_after = remain_r - 32'(len_w);
    more      = !rem_after[31] && (rem_after != 32'd0);
    cur_next  = cur_r + 32'(len_w);
    ovf       = !cur_r[31] && cur_next[31];
    len1_w    = (rem_after < res32) ? rem_after[RW-1:0] : res_w;
    next_abs  = cur_next[31] ? (32'd0 - cur_next) : cur_next;
  end

  // --------------------------------------------------------------------------
  // Piece combination walk
  // --------------------------------------------------------------------------
  logic i_last, j_last, k_last;
  logic emit_empty;
  logic emit_load;
  logic combo_last;

  always_comb begin
    i_last     = (i_r == (pn_r[0] == twds_pkg::PN_TWO));
    j_last     = (j_r == (pn_r[1] == twds_pkg::PN_TWO));
    k_last     = (k_r == (pn_r[2] == twds_pkg::PN_TWO));
    emit_empty = (pn_r[0] == twds_pkg::PN_NONE) || (pn_r[1] == twds_pkg::PN_NONE) ||
                 (pn_r[2] == twds_pkg::PN_NONE);
    emit_load  = !out_valid_r || !out_stall;
    combo_last = i_last && j_last && k_last;
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twds_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = twds_pkg::ST_SNAP_GO;
      end
      twds_pkg::ST_SNAP_GO: begin
        state_nxt = twds_pkg::ST_SNAP_WAIT;
      end
      twds_pkg::ST_SNAP_WAIT: begin
        if (div_resp.done) begin
          state_nxt = (ax_r == twds_pkg::AX_Z) ? twds_pkg::ST_PLAN : twds_pkg::ST_SNAP_GO;
        end
      end
      twds_pkg::ST_PLAN: begin
        state_nxt = twds_pkg::ST_SLAB;
      end
      twds_pkg::ST_SLAB: begin
        state_nxt = (init_pend_r || (mask_r != 3'd0)) ? twds_pkg::ST_AXIS
                                                       : twds_pkg::ST_FINISH;
      end
      twds_pkg::ST_AXIS: begin
        if (ax_has) begin
          state_nxt = twds_pkg::ST_MOD0_WAIT;
        end else begin
          state_nxt = (ax_r == twds_pkg::AX_Z) ? twds_pkg::ST_EMIT : twds_pkg::ST_AXIS;
        end
      end
      twds_pkg::ST_MOD0_WAIT: begin
        if (div_resp.done) state_nxt = twds_pkg::ST_PIECE0;
      end
      twds_pkg::ST_PIECE0: begin
        if (more && ovf) begin
          state_nxt = twds_pkg::ST_MOD1_WAIT;
        end else begin
          state_nxt = (ax_r == twds_pkg::AX_Z) ? twds_pkg::ST_EMIT : twds_pkg::ST_AXIS;
        end
      end
      twds_pkg::ST_MOD1_WAIT: begin
        if (div_resp.done) state_nxt = twds_pkg::ST_PIECE1;
      end
      twds_pkg::ST_PIECE1: begin
        state_nxt = (ax_r == twds_pkg::AX_Z) ? twds_pkg::ST_EMIT : twds_pkg::ST_AXIS;
      end
      twds_pkg::ST_EMIT: begin
        if (emit_empty || (emit_load && combo_last)) state_nxt = twds_pkg::ST_SLAB;
      end
      twds_pkg::ST_FINISH: begin
        state_nxt = twds_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = twds_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State outputs: input stall and divider request
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall         = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = cam_abs;
    div_req.divisor  = spacing_eff;
    case (state_r)
      twds_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      twds_pkg::ST_SNAP_GO: begin
        div_req.start = 1'b1;
      end
      twds_pkg::ST_AXIS: begin
        div_req.start    = ax_has;
        div_req.dividend = lo_abs;
        div_req.divisor  = twds_pkg::DIVS_W'(res_w);
      end
      twds_pkg::ST_PIECE0: begin
        div_req.start    = more && ovf;
        div_req.dividend = next_abs;
        div_req.divisor  = twds_pkg::DIVS_W'(res_w);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_res_r <= twds_pkg::GRID_RES_RST;
      spacing_r  <= twds_pkg::SPACING_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        twds_pkg::REG_GRID_RES: grid_res_r <= pwdata[twds_pkg::GRID_RES_W-1:0];
        twds_pkg::REG_SPACING:  spacing_r  <= pwdata[twds_pkg::SPACING_W-1:0];
        default: begin
          spacing_r <= spacing_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      twds_pkg::REG_GRID_RES: prdata = 32'(grid_res_r);
      twds_pkg::REG_SPACING:  prdata = 32'(spacing_r);
      default:                prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Window state: commit the new center at the end of the item
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) wc_r[a] <= 32'd0;
    end else if (state_r == twds_pkg::ST_FINISH) begin
      valid_r <= 1'b1;
      for (int a = 0; a < 3; a++) wc_r[a] <= nc_r[a];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r        <= twds_pkg::AX_X;
      slab_ax_r   <= twds_pkg::AX_X;
      mask_r      <= 3'd0;
      init_pend_r <= 1'b0;
      band_en_r   <= 1'b0;
      last_slab_r <= 1'b0;
      i_r         <= 1'b0;
      j_r         <= 1'b0;
      k_r         <= 1'b0;
    end else begin
      case (state_r)
        twds_pkg::ST_IDLE: begin
          ax_r <= twds_pkg::AX_X;
        end
        twds_pkg::ST_SNAP_WAIT: begin
          if (div_resp.done && (ax_r != twds_pkg::AX_Z)) ax_r <= ax_r + 2'd1;
        end
        twds_pkg::ST_PLAN: begin
          mask_r      <= valid_r ? moved : 3'd0;
          init_pend_r <= !valid_r;
        end
        twds_pkg::ST_SLAB: begin
          ax_r <= twds_pkg::AX_X;
          if (init_pend_r) begin
            // first item: full window on every axis
            init_pend_r <= 1'b0;
            band_en_r   <= 1'b0;
            last_slab_r <= 1'b1;
          end else if (mask_r[0]) begin
            mask_r      <= {mask_r[2:1], 1'b0};
            slab_ax_r   <= twds_pkg::AX_X;
            band_en_r   <= 1'b1;
            last_slab_r <= (mask_r[2:1] == 2'd0);
          end else if (mask_r[1]) begin
            mask_r      <= {mask_r[2], 2'b00};
            slab_ax_r   <= twds_pkg::AX_Y;
            band_en_r   <= 1'b1;
            last_slab_r <= !mask_r[2];
          end else if (mask_r[2]) begin
            mask_r      <= 3'd0;
            slab_ax_r   <= twds_pkg::AX_Z;
            band_en_r   <= 1'b1;
            last_slab_r <= 1'b1;
          end
        end
        twds_pkg::ST_AXIS: begin
          if (!ax_has && (ax_r != twds_pkg::AX_Z)) ax_r <= ax_r + 2'd1;
          i_r <= 1'b0;
          j_r <= 1'b0;
          k_r <= 1'b0;
        end
        twds_pkg::ST_PIECE0: begin
          if (!(more && ovf) && (ax_r != twds_pkg::AX_Z)) ax_r <= ax_r + 2'd1;
        end
        twds_pkg::ST_PIECE1: begin
          if (ax_r != twds_pkg::AX_Z) ax_r <= ax_r + 2'd1;
        end
        twds_pkg::ST_EMIT: begin
          // advance z fastest, x slowest
          if (!emit_empty && emit_load) begin
            if (!k_last) begin
              k_r <= 1'b1;
            end else begin
              k_r <= 1'b0;
              if (!j_last) begin
                j_r <= 1'b1;
              end else begin
                j_r <= 1'b0;
                i_r <= !i_last;
              end
            end
          end
        end
        default: begin
          ax_r <= ax_r;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers: camera, centers, motion flags, pieces
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      twds_pkg::ST_IDLE: begin
        cam_r[0] <= in_camera_x;
        cam_r[1] <= in_camera_y;
        cam_r[2] <= in_camera_z;
      end
      twds_pkg::ST_SNAP_WAIT: begin
        if (div_resp.done) nc_r[ax_r] <= snap_val;
      end
      twds_pkg::ST_PLAN: begin
        band_ok_r <= near;
        pos_r     <= fwd;
      end
      twds_pkg::ST_AXIS: begin
        cur_r    <= ax_lo;
        remain_r <= ax_len;
        if (!ax_has) pn_r[ax_r] <= twds_pkg::PN_NONE;
      end
      twds_pkg::ST_PIECE0: begin
        pw0_r[ax_r] <= cur_r;
        pt0_r[ax_r] <= wrap_w;
        pc0_r[ax_r] <= len_w;
        if (!more) begin
          pn_r[ax_r] <= twds_pkg::PN_ONE;
        end else if (!ovf) begin
          // next piece starts on a multiple of the resolution
          pw1_r[ax_r] <= cur_next;
          pt1_r[ax_r] <= '0;
          pc1_r[ax_r] <= len1_w;
          pn_r[ax_r]  <= twds_pkg::PN_TWO;
        end else begin
          cur_r    <= cur_next;
          remain_r <= rem_after;
        end
      end
      twds_pkg::ST_PIECE1: begin
        pw1_r[ax_r] <= cur_r;
        pt1_r[ax_r] <= wrap_w;
        pc1_r[ax_r] <= len_w;
        pn_r[ax_r]  <= twds_pkg::PN_TWO;
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Piece output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == twds_pkg::ST_EMIT) && !emit_empty && emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == twds_pkg::ST_EMIT) && !emit_empty && emit_load) begin
      o_world_r[0] <= i_r ? pw1_r[0] : pw0_r[0];
      o_world_r[1] <= j_r ? pw1_r[1] : pw0_r[1];
      o_world_r[2] <= k_r ? pw1_r[2] : pw0_r[2];
      o_texel_r[0] <= i_r ? pt1_r[0] : pt0_r[0];
      o_texel_r[1] <= j_r ? pt1_r[1] : pt0_r[1];
      o_texel_r[2] <= k_r ? pt1_r[2] : pt0_r[2];
      o_count_r[0] <= i_r ? pc1_r[0] : pc0_r[0];
      o_count_r[1] <= j_r ? pc1_r[1] : pc0_r[1];
      o_count_r[2] <= k_r ? pc1_r[2] : pc0_r[2];
      o_last_r     <= last_slab_r && combo_last;
    end
  end

  // Widen to the port widths, then keep the low bits
  logic [EW-1:0] tx_ext [3];
  logic [EW-1:0] cn_ext [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      tx_ext[a] = EW'(o_texel_r[a]);
      cn_ext[a] = EW'(o_count_r[a]);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_world_start_x = o_world_r[0];
  assign out_world_start_y = o_world_r[1];
  assign out_world_start_z = o_world_r[2];
  assign out_texel_start_x = tx_ext[0][twds_pkg::TEXEL_W-1:0];
  assign out_texel_start_y = tx_ext[1][twds_pkg::TEXEL_W-1:0];
  assign out_texel_start_z = tx_ext[2][twds_pkg::TEXEL_W-1:0];
  assign out_count_x       = cn_ext[0][twds_pkg::COUNT_W-1:0];
  assign out_count_y       = cn_ext[1][twds_pkg::COUNT_W-1:0];
  assign out_count_z       = cn_ext[2][twds_pkg::COUNT_W-1:0];
  assign out_last_piece    = o_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TWDS_CHECK_IMP(a_div_start_idle, div_req.start, !div_resp.busy, "divider restarted while busy")
  `TWDS_CHECK_NXT(a_window_kept, valid_r, valid_r, "window valid flag dropped")
  `TWDS_CHECK_IMP(a_out_from_emit, $rose(out_valid_r), $past(state_r == twds_pkg::ST_EMIT), "piece beat outside emit")
  `TWDS_CHECK_IMP(a_slab_nonempty, state_r == twds_pkg::ST_EMIT, !emit_empty, "slab with an empty axis")

endmodule

`default_nettype wire

FILE: design/twds_div.sv
// ----------------------------------------------------------------------------
// twds_div
// Unsigned restoring divider, one quotient bit per cycle, shared by the
// snap and the texel wrap computations.
// ----------------------------------------------------------------------------
`default_nettype none

module twds_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  twds_pkg::twds_div_req_t   req,
  output twds_pkg::twds_div_resp_t  resp
);

  localparam int CNT_W = $clog2(twds_pkg::DIVD_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [twds_pkg::DIVD_W-1:0]   dq_r, dq_nxt;
  logic [twds_pkg::DIVS_W-1:0]   rem_r, rem_nxt;
  logic [twds_pkg::DIVS_W-1:0]   dvs_r, dvs_nxt;
  logic [twds_pkg::DIVS_W:0]     trial;
  logic [twds_pkg::DIVS_W:0]     diff;
  logic                          ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem_r, dq_r[twds_pkg::DIVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  // Load on start, then shift one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[twds_pkg::DIVD_W-2:0], ge};
      rem_nxt = ge ? diff[twds_pkg::DIVS_W-1:0] : trial[twds_pkg::DIVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(twds_pkg::DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign resp.busy = busy_r;
  assign resp.done = done_r;
  assign resp.quot = dq_r;
  assign resp.rem  = rem_r;

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty-slab sequencer testbench
// Drives camera beats into the toroidal window sequencer, predicts every
// wrap-resolved dirty piece with its own window model, and checks each piece
// beat in order. A directed table covers reset state, extremes and register
// saturation; random phases then sweep register settings and camera walks
// under random input gaps on the camera channel and random piece stalls.
// ----------------------------------------------------------------------------

module testbench;
  import twds_pkg::*;

  localparam int MAX_RES    = 256;
  localparam int MAX_PIECES = 24;
  localparam int RAND_ITEMS = 130;
  localparam int QUIET_TAIL = 20;
  localparam int SETTLE     = 1500;
  localparam int HOLD_LEN   = 2500;
  localparam int LIMIT      = 1000000;

  typedef enum logic [1:0] {ROW_CAM, ROW_RES, ROW_SPACING} row_kind_e;
  typedef enum logic [1:0] {TY_PREDICT, TY_QUIET, TY_FIRST} row_ty_e;

  typedef struct packed {
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
    logic [7:0]  tx;
    logic [7:0]  ty;
    logic [7:0]  tz;
    logic [8:0]  cx;
    logic [8:0]  cy;
    logic [8:0]  cz;
    logic        last;
  } piece_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    row_ty_e     ty;
    piece_t      first;
  } row_t;

  // DUT connections
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_camera_x = '0;
  logic signed [31:0] in_camera_y = '0;
  logic signed [31:0] in_camera_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_world_start_x;
  logic signed [31:0] out_world_start_y;
  logic signed [31:0] out_world_start_z;
  logic [7:0]         out_texel_start_x;
  logic [7:0]         out_texel_start_y;
  logic [7:0]         out_texel_start_z;
  logic [8:0]         out_count_x;
  logic [8:0]         out_count_y;
  logic [8:0]         out_count_z;
  logic               out_last_piece;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Window model state and registers
  logic [8:0]  res_q;
  logic [23:0] spacing_q;
  logic [31:0] win_center [3];
  bit          win_valid;
  logic [31:0] slab_lo [3];
  logic [31:0] slab_hi [3];
  logic [31:0] span_world [3][2];
  logic [7:0]  span_texel [3][2];
  logic [8:0]  span_count [3][2];

  piece_t fresh_pieces [$];
  piece_t pieces_due [$];
  row_t   steps [$];

  int  err_cnt = 0;
  int  cams_sent = 0;
  int  pieces_seen = 0;
  int  reg_writes = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  logic [31:0] cam_pos [3];

  toroidal_window_dirty_slabs_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_camera_x       (in_camera_x),
    .in_camera_y       (in_camera_y),
    .in_camera_z       (in_camera_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_world_start_x (out_world_start_x),
    .out_world_start_y (out_world_start_y),
    .out_world_start_z (out_world_start_z),
    .out_texel_start_x (out_texel_start_x),
    .out_texel_start_y (out_texel_start_y),
    .out_texel_start_z (out_texel_start_z),
    .out_count_x       (out_count_x),
    .out_count_y       (out_count_y),
    .out_count_z       (out_count_z),
    .out_last_piece    (out_last_piece),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #2 clk = ~clk;

  function automatic piece_t mk_piece(int wx, int wy, int wz, int tx, int ty, int tz,
                                      int cx, int cy, int cz, bit last);
    piece_t p;
    p.wx = wx;       p.wy = wy;       p.wz = wz;
    p.tx = tx[7:0];  p.ty = ty[7:0];  p.tz = tz[7:0];
    p.cx = cx[8:0];  p.cy = cy[8:0];  p.cz = cz[8:0];
    p.last = last;
    return p;
  endfunction

  function automatic row_t mk_row(row_kind_e k, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, row_ty_e t, piece_t p);
    row_t r;
    r.kind = k;  r.a = a;  r.b = b;  r.c = c;  r.ty = t;  r.first = p;
    return r;
  endfunction

  function automatic int clamp_res();
    int r;
    r = res_q;
    if (r < 2) r = 2;
    if (r > MAX_RES) r = MAX_RES;
    return r;
  endfunction

  function automatic int eff_spacing();
    return (spacing_q == 0) ? 1 : int'(spacing_q);
  endfunction

  // Floor-divide one camera coordinate by the probe spacing
  function automatic logic [31:0] snap_probe(logic [31:0] raw);
    longint a;
    longint b;
    longint q;
    a = $signed(raw);
    b = eff_spacing();
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q[31:0];
  endfunction

  // Cut [lo, hi) on one axis into at most two texel-wrapped spans
  function automatic int split_axis(int ax, logic [31:0] lo, logic [31:0] hi, int res);
    longint left;
    longint w;
    longint len;
    logic [31:0] cur;
    int n;
    left = $signed(hi - lo);
    cur = lo;
    n = 0;
    while (left > 0 && n < 2) begin
      w = (($signed(cur) % res) + res) % res;
      len = res - w;
      if (left < len) len = left;
      span_world[ax][n] = cur;
      span_texel[ax][n] = w[7:0];
      span_count[ax][n] = len[8:0];
      n++;
      cur = cur + len[31:0];
      left = left - len;
    end
    return n;
  endfunction

  // Append every x*y*z span combination of the current slab
  task automatic emit_slab(int res);
    int nx;
    int ny;
    int nz;
    piece_t p;
    nx = split_axis(0, slab_lo[0], slab_hi[0], res);
    ny = split_axis(1, slab_lo[1], slab_hi[1], res);
    nz = split_axis(2, slab_lo[2], slab_hi[2], res);
    for (int i = 0; i < nx; i++)
      for (int j = 0; j < ny; j++)
        for (int k = 0; k < nz; k++) begin
          if (fresh_pieces.size() < MAX_PIECES) begin
            p.wx = span_world[0][i];  p.wy = span_world[1][j];  p.wz = span_world[2][k];
            p.tx = span_texel[0][i];  p.ty = span_texel[1][j];  p.tz = span_texel[2][k];
            p.cx = span_count[0][i];  p.cy = span_count[1][j];  p.cz = span_count[2][k];
            p.last = 1'b0;
            fresh_pieces.push_back(p);
          end
        end
  endtask

  // Work out the dirty pieces of one camera beat and advance the window
  task automatic plan_dirty_pieces(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    logic [31:0] nc [3];
    int res;
    int half;
    longint delta;
    longint mag;
    piece_t tail;
    res = clamp_res();
    half = res / 2;
    nc[0] = snap_probe(cx);
    nc[1] = snap_probe(cy);
    nc[2] = snap_probe(cz);
    fresh_pieces.delete();
    if (!win_valid) begin
      for (int ax = 0; ax < 3; ax++) begin
        slab_lo[ax] = nc[ax] - half;
        slab_hi[ax] = nc[ax] + half;
      end
      emit_slab(res);
      win_valid = 1'b1;
    end else begin
      for (int ax = 0; ax < 3; ax++) begin
        delta = $signed(nc[ax] - win_center[ax]);
        mag = (delta < 0) ? -delta : delta;
        if (delta != 0) begin
          for (int o = 0; o < 3; o++) begin
            slab_lo[o] = nc[o] - half;
            slab_hi[o] = nc[o] + half;
          end
          // Narrow the moved axis to the newly exposed band
          if (mag < res) begin
            if (delta > 0) begin
              slab_lo[ax] = win_center[ax] + half;
              slab_hi[ax] = nc[ax] + half;
            end else begin
              slab_lo[ax] = nc[ax] - half;
              slab_hi[ax] = win_center[ax] - half;
            end
          end
          emit_slab(res);
        end
      end
    end
    for (int ax = 0; ax < 3; ax++) win_center[ax] = nc[ax];
    if (fresh_pieces.size() > 0) begin
      tail = fresh_pieces.pop_back();
      tail.last = 1'b1;
      fresh_pieces.push_back(tail);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Offer one camera beat, hold it until taken, then queue its pieces
  task automatic offer_camera(row_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_camera_x <= r.a;
    in_camera_y <= r.b;
    in_camera_z <= r.c;
    do @(posedge clk); while (in_stall);
    cams_sent++;
    plan_dirty_pieces(r.a, r.b, r.c);
    if (r.ty != TY_QUIET) begin
      foreach (fresh_pieces[k])
        pieces_due.push_back((k == 0 && r.ty == TY_FIRST) ? r.first : fresh_pieces[k]);
    end
  endtask

  // Stop offering, wait out all pieces, then let the block settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pieces_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(logic idx, logic [31:0] val);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_GRID_RES) res_q = val[8:0];
    else spacing_q = val[23:0];
    want = (idx == REG_GRID_RES) ? {23'd0, res_q} : {8'd0, spacing_q};
    reg_writes++;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("prdata", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_res();
    case ($urandom_range(0, 5))
      0: return 32'd2;
      1: return MAX_RES;
      2: return $urandom_range(0, 511);
      3: return $urandom_range(1, 127) * 2 + 1;
      default: return $urandom_range(2, 96);
    endcase
  endfunction

  function automatic logic [31:0] pick_spacing();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1);
      1: return 32'hFF_FFFF;
      2: return $urandom_range(0, 32'hFF_FFFF);
      default: return $urandom_range(64, 1024);
    endcase
  endfunction

  // Next camera beat: mostly a short walk, sometimes a jump or a repeat
  function automatic row_t next_camera();
    int mode;
    int res;
    int sp;
    int step;
    res = clamp_res();
    sp = eff_spacing();
    mode = $urandom_range(0, 9);
    for (int ax = 0; ax < 3; ax++) begin
      if (mode == 0) begin
        cam_pos[ax] = $urandom;
      end else if (mode >= 2 && $urandom_range(0, 1) == 1) begin
        step = $urandom_range(0, 2 * res + 2) - (res + 1);
        if ($urandom_range(0, 3) != 0) step = $urandom_range(0, 6) - 3;
        cam_pos[ax] = cam_pos[ax] + step * sp;
        if ($urandom_range(0, 1) == 1) cam_pos[ax] = cam_pos[ax] + $urandom_range(0, sp - 1);
      end
    end
    return mk_row(ROW_CAM, cam_pos[0], cam_pos[1], cam_pos[2], TY_PREDICT, '0);
  endfunction

  // Piece sink: random stall bursts, one long hold-off on request
  initial begin : piece_sink
    bit held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        held = 1'b1;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted piece beat with the oldest expected piece
  always @(posedge clk) begin
    piece_t want;
    if (rst_n && out_valid && !out_stall) begin
      pieces_seen++;
      if (pieces_due.size() == 0) begin
        $error("piece beat with nothing expected: world %0h %0h %0h",
               out_world_start_x, out_world_start_y, out_world_start_z);
        err_cnt++;
      end else begin
        want = pieces_due.pop_front();
        check_field("world_start_x", want.wx, out_world_start_x);
        check_field("world_start_y", want.wy, out_world_start_y);
        check_field("world_start_z", want.wz, out_world_start_z);
        check_field("texel_start_x", want.tx, out_texel_start_x);
        check_field("texel_start_y", want.ty, out_texel_start_y);
        check_field("texel_start_z", want.tz, out_texel_start_z);
        check_field("count_x", want.cx, out_count_x);
        check_field("count_y", want.cy, out_count_y);
        check_field("count_z", want.cz, out_count_z);
        check_field("last_piece", want.last, out_last_piece);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    int rand_beats;
    int phase_len;
    rand_beats = 0;
    res_q = GRID_RES_RST;
    spacing_q = SPACING_RST;
    win_valid = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      win_center[ax] = '0;
      cam_pos[ax] = '0;
    end

    // Directed table: reset window, fraction inside a probe, one-probe move,
    // full refills, wrap past 2^31, register saturation and odd sizes
    steps.push_back(mk_row(ROW_CAM, 0, 0, 0, TY_FIRST,
                           mk_piece(-32, -32, -32, 32, 32, 32, 32, 32, 32, 0)));
    steps.push_back(mk_row(ROW_CAM, 0, 0, 0, TY_QUIET, '0));
    steps.push_back(mk_row(ROW_CAM, 255, 0, 0, TY_QUIET, '0));
    steps.push_back(mk_row(ROW_CAM, -1, 0, 0, TY_FIRST,
                           mk_piece(-33, -32, -32, 31, 32, 32, 1, 32, 32, 0)));
    steps.push_back(mk_row(ROW_CAM, 768, 512, -256, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 32'h7FFF_FFFF, 32'h8000_0000, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_SPACING, 0, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 0, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 32'h8000_0000, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 32'h7FFF_FFF0, 32'h7FFF_FFE0, 32'h8000_0010,
                           TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 32'h7FFF_FFF8, 32'h7FFF_FFE4, 32'h8000_000C,
                           TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_RES, 0, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 5, 5, 5, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 6, 4, 5, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_RES, 511, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, -7, 100, 300, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_RES, 63, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 1, 2, 3, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, -40, -1, 70, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_SPACING, 32'hFF_FFFF, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                           TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_RES, 1, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 0, 32'h0100_0000, -1, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_RES, 2, 0, 0, TY_PREDICT, '0));
    steps.push_back(mk_row(ROW_CAM, 32'h0300_0000, 32'h0100_0000, 32'hFE00_0000,
                           TY_PREDICT, '0));

    // Hold reset, then release
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Walk the directed table
    foreach (steps[i]) begin
      case (steps[i].kind)
        ROW_CAM: begin
          offer_camera(steps[i]);
        end
        ROW_RES: begin
          wait_drain();
          write_reg(REG_GRID_RES, steps[i].a);
        end
        default: begin
          wait_drain();
          write_reg(REG_SPACING, steps[i].a);
        end
      endcase
    end

    // Random phases: drain, retune both registers, then a run of cameras
    while (rand_beats < RAND_ITEMS) begin
      wait_drain();
      write_reg(REG_GRID_RES, pick_res());
      write_reg(REG_SPACING, pick_spacing());
      phase_len = $urandom_range(6, 14);
      repeat (phase_len) begin
        quiet = (rand_beats >= RAND_ITEMS - QUIET_TAIL);
        offer_camera(next_camera());
        rand_beats++;
        if (rand_beats == 30) hold_req = 1'b1;
      end
    end
    wait_drain();

    $display("summary: %0d camera beats, %0d piece beats, %0d register writes",
             cams_sent, pieces_seen, reg_writes);
    $display("summary: directed extremes plus random walks over many window settings");
    if (err_cnt == 0 && pieces_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
